[rtl/tkf_pkg.sv]
// Shared types, constants and helpers for the three-axis tilt Kalman unit.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none
package tkf_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int NUM_AXES    = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_NOISE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_OFFSET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE    = 3'd7;

    localparam logic [15:0] TIME_STEP_RST     = 16'd1311;
    localparam logic [15:0] ANGLE_NOISE_RST   = 16'd66;
    localparam logic [15:0] GYRO_NOISE_RST    = 16'd197;
    localparam logic [19:0] MEASURE_NOISE_RST = 20'd45875;

    // Divider widths: numerator holds a Q16.16 value shifted up by 16 bits.
    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 34;
    localparam int PROD_W    = 66;

    // ceil(2^34 / 3): (x * RECIP_3) >> 34 equals floor(x / 3) for any x below 2^33.
    localparam logic [32:0] RECIP_3 = 33'd5726623062;

    typedef struct packed {
        logic [15:0]            time_step;
        logic [15:0]            angle_noise;
        logic [15:0]            gyro_noise;
        logic [19:0]            measure_noise;
        logic [SAMPLE_BITS-1:0] accel_offset;
        logic signed [31:0]     accel_scale;
        logic [SAMPLE_BITS-1:0] gyro_offset;
        logic signed [31:0]     gyro_scale;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] accel_x;
        logic [SAMPLE_BITS-1:0] accel_y;
        logic [SAMPLE_BITS-1:0] accel_z;
        logic [SAMPLE_BITS-1:0] rate_x;
        logic [SAMPLE_BITS-1:0] rate_y;
        logic [SAMPLE_BITS-1:0] rate_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [31:0] bias_x;
        logic signed [31:0] bias_y;
        logic signed [31:0] bias_z;
    } out_item_t;

    typedef enum logic [4:0] {
        LS_IDLE, LS_ACC, LS_CUR, LS_SUM, LS_RDIV, LS_ANG,
        LS_P0, LS_P1, LS_P2, LS_P3, LS_P4, LS_K0, LS_K1,
        LS_U0, LS_U1, LS_U2, LS_U3, LS_U4, LS_U5, LS_U6
    } lane_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/three_axis_tilt_kalman_unit.sv]
// Three-axis tilt Kalman unit: configuration registers, three axis lanes and the
// result register that merges them. Depends on tkf_pkg, tkf_lane and tkf_div.
//
// Usage:
//   Configuration is written through cfg_we/cfg_idx/cfg_wdata while the unit is idle;
//   a write takes effect at the clock edge where cfg_we is high.
//   An item on s_data (raw accelerometer and gyro samples of x, y, z) is accepted
//   when s_valid and s_ready are high. The three axes run in parallel lanes, each
//   with one multiplier and one bit-serial divider. From acceptance to m_valid,
//   two gain divisions per lane take most of the time, the rest being multiply
//   and control steps. When the innovation variance of every axis is zero the
//   lanes skip the gain divisions.
//   Items are processed one at a time; s_ready returns the cycle after the result
//   register loads.
//   The result (three angles, three biases) sits in an output register until
//   m_ready takes it; the next item may be accepted and computed meanwhile, and
//   its result waits until the register is free.
//   Reset (aresetn low, synchronous) loads the register defaults and clears the
//   rate history, estimates and covariances.
`default_nettype none
module three_axis_tilt_kalman_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [tkf_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire logic [tkf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire tkf_pkg::in_item_t                  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output tkf_pkg::out_item_t                      m_data
);
    localparam int SB = tkf_pkg::SAMPLE_BITS;
    localparam int NA = tkf_pkg::NUM_AXES;

    tkf_pkg::cfg_t      cfg_reg;
    tkf_pkg::out_item_t out_reg;
    logic               busy_reg, busy_next;
    logic               ovalid_reg, ovalid_next;
    logic [NA-1:0]      fin_reg, fin_next;
    logic [NA-1:0]      lane_done;
    logic               start;
    logic               load;
    logic [SB-1:0]      raw_a [NA];
    logic [SB-1:0]      raw_g [NA];
    logic signed [31:0] angle [NA];
    logic signed [31:0] bias  [NA];

    assign s_ready = !busy_reg;
    assign start   = s_valid && s_ready;

    assign raw_a[0] = s_data.accel_x;
    assign raw_a[1] = s_data.accel_y;
    assign raw_a[2] = s_data.accel_z;
    assign raw_g[0] = s_data.rate_x;
    assign raw_g[1] = s_data.rate_y;
    assign raw_g[2] = s_data.rate_z;

    for (genvar a = 0; a < NA; a++) begin : g_lane
        tkf_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (start),
            .raw_a   (raw_a[a]),
            .raw_g   (raw_g[a]),
            .cfg     (cfg_reg),
            .done    (lane_done[a]),
            .angle   (angle[a]),
            .bias    (bias[a])
        );
    end

    // The result register loads once every lane has finished and the previous item is gone.
    always_comb begin
        fin_next    = fin_reg | lane_done;
        load        = busy_reg && (&fin_next) && (!ovalid_reg || m_ready);
        ovalid_next = ovalid_reg && !m_ready;
        busy_next   = busy_reg;
        if (load) begin
            ovalid_next = 1'b1;
            busy_next   = 1'b0;
            fin_next    = '0;
        end
        if (start) begin
            busy_next = 1'b1;
            fin_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg              <= 1'b0;
            ovalid_reg            <= 1'b0;
            fin_reg               <= '0;
            cfg_reg.time_step     <= tkf_pkg::TIME_STEP_RST;
            cfg_reg.angle_noise   <= tkf_pkg::ANGLE_NOISE_RST;
            cfg_reg.gyro_noise    <= tkf_pkg::GYRO_NOISE_RST;
            cfg_reg.measure_noise <= tkf_pkg::MEASURE_NOISE_RST;
            cfg_reg.accel_offset  <= '0;
            cfg_reg.accel_scale   <= '0;
            cfg_reg.gyro_offset   <= '0;
            cfg_reg.gyro_scale    <= '0;
        end else begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            fin_reg    <= fin_next;
            if (cfg_we) begin
                case (cfg_idx)
                    tkf_pkg::REG_TIME_STEP:     cfg_reg.time_step     <= cfg_wdata[15:0];
                    tkf_pkg::REG_ANGLE_NOISE:   cfg_reg.angle_noise   <= cfg_wdata[15:0];
                    tkf_pkg::REG_GYRO_NOISE:    cfg_reg.gyro_noise    <= cfg_wdata[15:0];
                    tkf_pkg::REG_MEASURE_NOISE: cfg_reg.measure_noise <= cfg_wdata[19:0];
                    tkf_pkg::REG_ACCEL_OFFSET:  cfg_reg.accel_offset  <= cfg_wdata[SB-1:0];
                    tkf_pkg::REG_ACCEL_SCALE:   cfg_reg.accel_scale   <= cfg_wdata;
                    tkf_pkg::REG_GYRO_OFFSET:   cfg_reg.gyro_offset   <= cfg_wdata[SB-1:0];
                    tkf_pkg::REG_GYRO_SCALE:    cfg_reg.gyro_scale    <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        if (load) begin
            out_reg.angle_x <= angle[0];
            out_reg.angle_y <= angle[1];
            out_reg.angle_z <= angle[2];
            out_reg.bias_x  <= bias[0];
            out_reg.bias_y  <= bias[1];
            out_reg.bias_z  <= bias[2];
        end
    end

    assign m_valid = ovalid_reg;
    assign m_data  = out_reg;
endmodule
`default_nettype wire

[rtl/tkf_div.sv]
// Iterative signed divider, one quotient bit per cycle, quotient truncated toward zero.
// Depends on tkf_pkg for widths.
`default_nettype none
module tkf_div (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [tkf_pkg::DIV_NUM_W-1:0] num,
    input  wire logic signed [tkf_pkg::DIV_DEN_W-1:0] den,
    output logic                                      done,
    output logic signed [tkf_pkg::DIV_NUM_W-1:0]      quo
);
    localparam int NW = tkf_pkg::DIV_NUM_W;
    localparam int DW = tkf_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [NW-1:0] n_reg, n_next;
    logic [DW-1:0] d_reg, d_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    assign shifted = {rem_reg, n_reg[NW-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            neg_next  = num[NW-1] ^ den[DW-1];
            n_next    = num[NW-1] ? NW'(-num) : NW'(num);
            d_next    = den[DW-1] ? DW'(-den) : DW'(den);
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_next = diff[DW-1:0];
            end else begin
                rem_next = shifted[DW-1:0];
            end
            n_next   = {n_reg[NW-2:0], ~diff[DW]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(n_reg) : $signed(n_reg);
endmodule
`default_nettype wire

[rtl/tkf_lane.sv]
// One axis of the filter: sample scaling, rate smoothing and the angle/bias Kalman step.
// A sequencer drives one shared multiplier and one tkf_div; depends on tkf_pkg.
`default_nettype none
module tkf_lane (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [tkf_pkg::SAMPLE_BITS-1:0]    raw_a,
    input  wire logic [tkf_pkg::SAMPLE_BITS-1:0]    raw_g,
    input  wire tkf_pkg::cfg_t                      cfg,
    output logic                                    done,
    output logic signed [31:0]                      angle,
    output logic signed [31:0]                      bias
);
    localparam int SB = tkf_pkg::SAMPLE_BITS;
    localparam int PW = tkf_pkg::PROD_W;
    localparam int NW = tkf_pkg::DIV_NUM_W;
    localparam int DW = tkf_pkg::DIV_DEN_W;

    tkf_pkg::lane_state_t state_reg, state_next;

    logic [SB-1:0]        ra_reg, rg_reg;
    logic signed [31:0]   h0_reg, h1_reg, h2_reg;
    logic signed [31:0]   angle_reg, bias_reg;
    logic signed [31:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0]   acc_reg, y_reg, k0_reg, k1_reg;
    logic signed [PW-1:0] tmp_reg;
    logic signed [DW-1:0] s_reg;
    logic signed [PW-1:0] prod_reg;
    logic [32:0]          half_reg;
    logic                 sneg_reg;

    logic signed [32:0]   mul_a, mul_b;
    logic signed [PW-1:0] rnd;
    logic                 div_start, div_done;
    logic signed [NW-1:0] div_num, quo;
    logic signed [DW-1:0] div_den;

    logic signed [32:0]   da, dg, dt, qa, qg;
    logic signed [PW-1:0] sum, s_full;
    logic signed [31:0]   err, psum, qsat;
    logic [PW-1:0]        sum_mag;
    logic [65:0]          q_prod;
    logic signed [31:0]   rate_q;

    assign da  = $signed({(33 - SB)'(0), ra_reg}) - $signed({(33 - SB)'(0), cfg.accel_offset});
    assign dg  = $signed({(33 - SB)'(0), rg_reg}) - $signed({(33 - SB)'(0), cfg.gyro_offset});
    assign dt  = $signed({17'd0, cfg.time_step});
    assign qa  = $signed({17'd0, cfg.angle_noise});
    assign qg  = $signed({17'd0, cfg.gyro_noise});
    assign rnd = (prod_reg + PW'(32768)) >>> 16;
    assign sum = PW'(h2_reg) + (PW'(h1_reg) <<< 1) + (PW'(h0_reg) <<< 1)
               + PW'(tkf_pkg::sat32(prod_reg));
    assign err  = tkf_pkg::sat32(PW'(h0_reg) - PW'(bias_reg));
    assign psum = tkf_pkg::sat32(PW'(p01_reg) + PW'(p10_reg));
    assign qsat = tkf_pkg::sat32(PW'(quo));
    assign s_full = PW'(p00_reg) + $signed({(PW - 20)'(0), cfg.measure_noise});

    // The average divides the magnitude by two, then by three through a reciprocal
    // product, and restores the sign, so the quotient truncates toward zero.
    assign sum_mag = sum[PW-1] ? -sum : sum;
    assign q_prod  = {33'd0, half_reg} * {33'd0, tkf_pkg::RECIP_3};
    assign rate_q  = sneg_reg ? -q_prod[65:34] : q_prod[65:34];

    tkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tkf_pkg::LS_IDLE: if (start) state_next = tkf_pkg::LS_ACC;
            tkf_pkg::LS_ACC:  state_next = tkf_pkg::LS_CUR;
            tkf_pkg::LS_CUR:  state_next = tkf_pkg::LS_SUM;
            tkf_pkg::LS_SUM:  state_next = tkf_pkg::LS_RDIV;
            tkf_pkg::LS_RDIV: state_next = tkf_pkg::LS_ANG;
            tkf_pkg::LS_ANG:  state_next = tkf_pkg::LS_P0;
            tkf_pkg::LS_P0:   state_next = tkf_pkg::LS_P1;
            tkf_pkg::LS_P1:   state_next = tkf_pkg::LS_P2;
            tkf_pkg::LS_P2:   state_next = tkf_pkg::LS_P3;
            tkf_pkg::LS_P3:   state_next = tkf_pkg::LS_P4;
            tkf_pkg::LS_P4:   state_next = (s_full == '0) ? tkf_pkg::LS_U0 : tkf_pkg::LS_K0;
            tkf_pkg::LS_K0:   if (div_done) state_next = tkf_pkg::LS_K1;
            tkf_pkg::LS_K1:   if (div_done) state_next = tkf_pkg::LS_U0;
            tkf_pkg::LS_U0:   state_next = tkf_pkg::LS_U1;
            tkf_pkg::LS_U1:   state_next = tkf_pkg::LS_U2;
            tkf_pkg::LS_U2:   state_next = tkf_pkg::LS_U3;
            tkf_pkg::LS_U3:   state_next = tkf_pkg::LS_U4;
            tkf_pkg::LS_U4:   state_next = tkf_pkg::LS_U5;
            tkf_pkg::LS_U5:   state_next = tkf_pkg::LS_U6;
            tkf_pkg::LS_U6:   state_next = tkf_pkg::LS_IDLE;
            default:          state_next = tkf_pkg::LS_IDLE;
        endcase
    end

    // Multiplier operands, divider requests and the done strobe; each product is consumed one state later.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        done      = 1'b0;
        case (state_reg)
            tkf_pkg::LS_ACC: begin mul_a = da; mul_b = 33'(cfg.accel_scale); end
            tkf_pkg::LS_CUR: begin mul_a = dg; mul_b = 33'(cfg.gyro_scale); end
            tkf_pkg::LS_ANG: begin mul_a = 33'(err); mul_b = dt; end
            tkf_pkg::LS_P0:  begin mul_a = dt; mul_b = 33'(psum); end
            tkf_pkg::LS_P1:  begin mul_a = qa; mul_b = dt; end
            tkf_pkg::LS_P2:  begin mul_a = dt; mul_b = 33'(p11_reg); end
            tkf_pkg::LS_P3:  begin mul_a = qg; mul_b = dt; end
            tkf_pkg::LS_P4: begin
                div_start = (s_full != '0);
                div_num   = NW'($signed({p00_reg, 16'h0000}));
                div_den   = DW'(s_full);
            end
            tkf_pkg::LS_K0: begin
                div_start = div_done;
                div_num   = NW'($signed({p10_reg, 16'h0000}));
                div_den   = s_reg;
            end
            tkf_pkg::LS_U0:  begin mul_a = 33'(k0_reg); mul_b = 33'(y_reg); end
            tkf_pkg::LS_U1:  begin mul_a = 33'(k1_reg); mul_b = 33'(y_reg); end
            tkf_pkg::LS_U2:  begin mul_a = 33'(k1_reg); mul_b = 33'(p00_reg); end
            tkf_pkg::LS_U3:  begin mul_a = 33'(k0_reg); mul_b = 33'(p00_reg); end
            tkf_pkg::LS_U4:  begin mul_a = 33'(k1_reg); mul_b = 33'(p01_reg); end
            tkf_pkg::LS_U5:  begin mul_a = 33'(k0_reg); mul_b = 33'(p01_reg); end
            tkf_pkg::LS_U6:  done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tkf_pkg::LS_IDLE;
            h0_reg    <= '0;
            h1_reg    <= '0;
            h2_reg    <= '0;
            angle_reg <= '0;
            bias_reg  <= '0;
            p00_reg   <= '0;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                tkf_pkg::LS_RDIV: begin
                    h2_reg <= h1_reg;
                    h1_reg <= h0_reg;
                    h0_reg <= rate_q;
                end
                tkf_pkg::LS_P0: angle_reg <= tkf_pkg::sat32(PW'(angle_reg) + rnd);
                tkf_pkg::LS_P2: p00_reg <= tkf_pkg::sat32(PW'(p00_reg) - tmp_reg + rnd);
                tkf_pkg::LS_P3: begin
                    p01_reg <= tkf_pkg::sat32(PW'(p01_reg) - rnd);
                    p10_reg <= tkf_pkg::sat32(PW'(p10_reg) - rnd);
                end
                tkf_pkg::LS_P4: p11_reg <= tkf_pkg::sat32(PW'(p11_reg) + rnd);
                tkf_pkg::LS_U1: angle_reg <= tkf_pkg::sat32(PW'(angle_reg) + rnd);
                tkf_pkg::LS_U2: bias_reg <= tkf_pkg::sat32(PW'(bias_reg) + rnd);
                tkf_pkg::LS_U3: p10_reg <= tkf_pkg::sat32(PW'(p10_reg) - rnd);
                tkf_pkg::LS_U4: p00_reg <= tkf_pkg::sat32(PW'(p00_reg) - rnd);
                tkf_pkg::LS_U5: p11_reg <= tkf_pkg::sat32(PW'(p11_reg) - rnd);
                tkf_pkg::LS_U6: p01_reg <= tkf_pkg::sat32(PW'(p01_reg) - rnd);
                default: ;
            endcase
        end
        prod_reg <= mul_a * mul_b;
        if (state_reg == tkf_pkg::LS_IDLE && start) begin
            ra_reg <= raw_a;
            rg_reg <= raw_g;
        end
        if (state_reg == tkf_pkg::LS_CUR) begin
            acc_reg <= tkf_pkg::sat32(prod_reg);
        end
        if (state_reg == tkf_pkg::LS_SUM) begin
            half_reg <= sum_mag[33:1];
            sneg_reg <= sum[PW-1];
        end
        if (state_reg == tkf_pkg::LS_P1) begin
            tmp_reg <= rnd;
        end
        if (state_reg == tkf_pkg::LS_P4) begin
            s_reg  <= DW'(s_full);
            y_reg  <= tkf_pkg::sat32(PW'(acc_reg) - PW'(angle_reg));
            k0_reg <= '0;
            k1_reg <= '0;
        end
        if (state_reg == tkf_pkg::LS_K0 && div_done) begin
            k0_reg <= qsat;
        end
        if (state_reg == tkf_pkg::LS_K1 && div_done) begin
            k1_reg <= qsat;
        end
    end

    assign angle = angle_reg;
    assign bias  = bias_reg;
endmodule
`default_nettype wire
